// ----- sv/reb_pkg.sv -----
// Shared types and constants for the rotary encoder and button qualifier.
package reb_pkg;

   // Field and register widths
   localparam int MS_W    = 32;
   localparam int CFG_W   = 16;
   localparam int STEP_W  = 8;
   localparam int INDEX_W = 2;

   typedef logic [MS_W-1:0]          ms_type;
   typedef logic [CFG_W-1:0]         cfg_type;
   typedef logic signed [STEP_W-1:0] step_type;
   typedef logic [INDEX_W-1:0]       index_type;

   // Register indexes on the configuration port
   localparam index_type REG_ROTATION_HOLDOFF = 2'd0;
   localparam index_type REG_BUTTON_DEBOUNCE  = 2'd1;
   localparam index_type REG_LONG_PRESS       = 2'd2;

   // Register reset values
   localparam cfg_type ROTATION_HOLDOFF_RST = 16'd5;
   localparam cfg_type BUTTON_DEBOUNCE_RST  = 16'd50;
   localparam cfg_type LONG_PRESS_RST       = 16'd1000;

   // Step count saturation limits
   localparam step_type STEP_MAX = 8'sd127;
   localparam step_type STEP_MIN = -8'sd128;

   // One pin sample as held in the input stage
   typedef struct packed {
      logic   clock_level;
      logic   data_level;
      logic   button_level;
      ms_type now_ms;
      logic   take_rotation;
      logic   take_short_press;
      logic   take_long_press;
   } sample_type;

   // Button status handed from the button logic to the result register
   typedef struct packed {
      logic short_press;
      logic long_press;
      logic button_held;
   } button_status_type;

endpackage

// ----- sv/reb_encoder.sv -----
// Encoder edge detection, rotation holdoff and saturating step count.
module reb_encoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             clock_level,
   input  logic             data_level,
   input  reb_pkg::ms_type  now_ms,
   input  logic             take_rotation,
   input  reb_pkg::cfg_type holdoff_ms,
   output reb_pkg::step_type rotation_steps
);
   import reb_pkg::*;

   logic     prev_clock_ff, prev_clock_in;
   step_type step_ff, step_in;
   ms_type   last_step_ff, last_step_in;

   ms_type   since_step;
   logic     count_step;
   step_type step_next;

   // Count a rising edge once the holdoff has elapsed
   always_comb begin
      since_step = now_ms - last_step_ff;
      count_step = (clock_level != prev_clock_ff) && clock_level &&
                   (since_step >= {{(MS_W-CFG_W){1'b0}}, holdoff_ms});
      step_next  = step_ff;
      if (count_step) begin
         if (!data_level) begin
            if (step_ff != STEP_MAX) begin
               step_next = step_ff + 8'sd1;
            end
         end else begin
            if (step_ff != STEP_MIN) begin
               step_next = step_ff - 8'sd1;
            end
         end
      end
      prev_clock_in = clock_level;
      last_step_in  = count_step ? now_ms : last_step_ff;
      step_in       = take_rotation ? '0 : step_next;
   end

   assign rotation_steps = step_next;

   // Update state once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_clock_ff <= 1'b1;
         step_ff       <= '0;
         last_step_ff  <= '0;
      end else if (advance) begin
         prev_clock_ff <= prev_clock_in;
         step_ff       <= step_in;
         last_step_ff  <= last_step_in;
      end
   end

endmodule

// ----- sv/reb_button.sv -----
// Button debounce, short-press and long-press detection.
module reb_button (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       button_level,
   input  reb_pkg::ms_type            now_ms,
   input  logic                       take_short_press,
   input  logic                       take_long_press,
   input  reb_pkg::cfg_type           debounce_thresh,
   input  reb_pkg::cfg_type           hold_thresh,
   output reb_pkg::button_status_type status
);
   import reb_pkg::*;

   logic   prev_raw_ff, prev_raw_in;
   logic   held_ff, held_in;
   logic   short_ff, short_in;
   logic   long_ff, long_in;
   logic   fired_ff, fired_in;
   ms_type change_time_ff, change_time_in;
   ms_type press_start_ff, press_start_in;

   logic   pressed_raw;
   logic   raw_changed;
   logic   settle;
   ms_type since_change;
   ms_type since_press;
   logic   short_mid;
   logic   fired_mid;
   logic   long_mid;

   always_comb begin
      pressed_raw  = !button_level;
      raw_changed  = (pressed_raw != prev_raw_ff);
      since_change = now_ms - change_time_ff;

      // Restart the stable timer on a raw change, else let the debounced state follow
      settle = !raw_changed && (pressed_raw != held_ff) &&
               (since_change >= {{(MS_W-CFG_W){1'b0}}, debounce_thresh});
      prev_raw_in    = pressed_raw;
      change_time_in = raw_changed ? now_ms : change_time_ff;
      held_in        = settle ? pressed_raw : held_ff;
      press_start_in = press_start_ff;
      short_mid      = short_ff;
      fired_mid      = fired_ff;
      if (settle) begin
         if (pressed_raw) begin
            press_start_in = now_ms;
         end else if (!fired_ff) begin
            short_mid = 1'b1;
         end
         fired_mid = 1'b0;
      end

      // Fire the long press once per hold
      since_press = now_ms - press_start_in;
      long_mid    = long_ff;
      fired_in    = fired_mid;
      if (held_in && !fired_mid &&
          (since_press >= {{(MS_W-CFG_W){1'b0}}, hold_thresh})) begin
         long_mid = 1'b1;
         fired_in = 1'b1;
      end

      status.short_press = short_mid;
      status.long_press  = long_mid;
      status.button_held = held_in;

      // Drop what the transaction takes after reporting it
      short_in = short_mid && !take_short_press;
      long_in  = long_mid && !take_long_press;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff    <= 1'b0;
         held_ff        <= 1'b0;
         short_ff       <= 1'b0;
         long_ff        <= 1'b0;
         fired_ff       <= 1'b0;
         change_time_ff <= '0;
         press_start_ff <= '0;
      end else if (advance) begin
         prev_raw_ff    <= prev_raw_in;
         held_ff        <= held_in;
         short_ff       <= short_in;
         long_ff        <= long_in;
         fired_ff       <= fired_in;
         change_time_ff <= change_time_in;
         press_start_ff <= press_start_in;
      end
   end

endmodule

// ----- sv/rotary_encoder_button_qualifier_top.sv -----
// Top level of the rotary encoder and push-button qualifier.
// Each transaction is one pin sample with a millisecond timestamp and yields
// exactly one result: the saturating pending step count, the short- and
// long-press flags and the debounced button state. A sample is taken when
// req_valid is high and req_stall is low; it is held in the input register,
// and the encoder and button state update on the same edge that loads the
// result register. Throughput is one transaction per cycle while the result
// channel does not stall, set by the state update loop. A stalled result holds
// in the result register while the next sample still enters the input register.
// Write the three timing registers only while no transaction is in flight.
module rotary_encoder_button_qualifier_top (
   input  logic               clock,
   input  logic               reset,
   // Sample channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_clock_level,
   input  logic               req_data_level,
   input  logic               req_button_level,
   input  reb_pkg::ms_type    req_now_ms,
   input  logic               req_take_rotation,
   input  logic               req_take_short_press,
   input  logic               req_take_long_press,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output reb_pkg::step_type  rsp_rotation_steps,
   output logic               rsp_short_press,
   output logic               rsp_long_press,
   output logic               rsp_button_held,
   // Register write port
   input  logic               csr_wr_en,
   input  reb_pkg::index_type csr_index,
   input  reb_pkg::cfg_type   csr_wr_data
);
   import reb_pkg::*;

   cfg_type           holdoff_ff, debounce_ff, long_press_ff;
   logic              stg_valid_ff, stg_valid_in;
   sample_type        stg_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   step_type          rsp_steps_ff;
   button_status_type rsp_status_ff;

   logic              out_free;
   logic              advance;
   logic              req_take;
   step_type          steps;
   button_status_type status;

   // Write timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff    <= ROTATION_HOLDOFF_RST;
         debounce_ff   <= BUTTON_DEBOUNCE_RST;
         long_press_ff <= LONG_PRESS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ROTATION_HOLDOFF: holdoff_ff    <= csr_wr_data;
            REG_BUTTON_DEBOUNCE:  debounce_ff   <= csr_wr_data;
            REG_LONG_PRESS:       long_press_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Pipeline flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = stg_valid_ff && out_free;
   assign req_stall = stg_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign stg_valid_in = req_take || (stg_valid_ff && !out_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Hold the incoming sample
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_ff.clock_level      <= req_clock_level;
         stg_ff.data_level       <= req_data_level;
         stg_ff.button_level     <= req_button_level;
         stg_ff.now_ms           <= req_now_ms;
         stg_ff.take_rotation    <= req_take_rotation;
         stg_ff.take_short_press <= req_take_short_press;
         stg_ff.take_long_press  <= req_take_long_press;
      end
   end

   reb_encoder u_encoder (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .clock_level    (stg_ff.clock_level),
      .data_level     (stg_ff.data_level),
      .now_ms         (stg_ff.now_ms),
      .take_rotation  (stg_ff.take_rotation),
      .holdoff_ms     (holdoff_ff),
      .rotation_steps (steps)
   );

   reb_button u_button (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .button_level     (stg_ff.button_level),
      .now_ms           (stg_ff.now_ms),
      .take_short_press (stg_ff.take_short_press),
      .take_long_press  (stg_ff.take_long_press),
      .debounce_thresh  (debounce_ff),
      .hold_thresh      (long_press_ff),
      .status           (status)
   );

   // Capture the result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_steps_ff  <= steps;
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rotation_steps = rsp_steps_ff;
   assign rsp_short_press    = rsp_status_ff.short_press;
   assign rsp_long_press     = rsp_status_ff.long_press;
   assign rsp_button_held    = rsp_status_ff.button_held;

   // A sample blocked in the input register stays there
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && !out_free) |=> stg_valid_ff)
      else $error("input stage dropped a blocked sample");

   // A new sample is taken only when the input register can pass its content on
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!stg_valid_ff || out_free))
      else $error("input stage overwritten while blocked");

   // Every processed sample produces a result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed sample did not produce a result");

   // A waiting result is not replaced
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(rsp_steps_ff) && $stable(rsp_status_ff)))
      else $error("waiting result replaced");

endmodule
